/* rtl/core/ncc_pkg.sv */
// shared types and opcode constants for the nibble processor core
package ncc_pkg;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_HALT = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  localparam logic [3:0] GRP_JCN = 4'h1;
  localparam logic [3:0] GRP_FIM = 4'h2;
  localparam logic [3:0] GRP_FIN = 4'h3;
  localparam logic [3:0] GRP_JUN = 4'h4;
  localparam logic [3:0] GRP_JMS = 4'h5;
  localparam logic [3:0] GRP_INC = 4'h6;
  localparam logic [3:0] GRP_ISZ = 4'h7;
  localparam logic [3:0] GRP_ADD = 4'h8;
  localparam logic [3:0] GRP_SUB = 4'h9;
  localparam logic [3:0] GRP_LD  = 4'hA;
  localparam logic [3:0] GRP_XCH = 4'hB;
  localparam logic [3:0] GRP_BBL = 4'hC;
  localparam logic [3:0] GRP_LDM = 4'hD;
  localparam logic [3:0] GRP_IO  = 4'hE;
  localparam logic [3:0] GRP_ACC = 4'hF;

  localparam logic [3:0] IO_WRM = 4'h0;
  localparam logic [3:0] IO_WMP = 4'h1;
  localparam logic [3:0] IO_WR0 = 4'h4;
  localparam logic [3:0] IO_WR1 = 4'h5;
  localparam logic [3:0] IO_WR2 = 4'h6;
  localparam logic [3:0] IO_WR3 = 4'h7;
  localparam logic [3:0] IO_SBM = 4'h8;
  localparam logic [3:0] IO_RDM = 4'h9;
  localparam logic [3:0] IO_RDR = 4'hA;
  localparam logic [3:0] IO_ADM = 4'hB;
  localparam logic [3:0] IO_RD0 = 4'hC;
  localparam logic [3:0] IO_RD1 = 4'hD;
  localparam logic [3:0] IO_RD2 = 4'hE;
  localparam logic [3:0] IO_RD3 = 4'hF;

  localparam logic [3:0] AC_CLB = 4'h0;
  localparam logic [3:0] AC_CLC = 4'h1;
  localparam logic [3:0] AC_IAC = 4'h2;
  localparam logic [3:0] AC_CMC = 4'h3;
  localparam logic [3:0] AC_CMA = 4'h4;
  localparam logic [3:0] AC_RAL = 4'h5;
  localparam logic [3:0] AC_RAR = 4'h6;
  localparam logic [3:0] AC_TCC = 4'h7;
  localparam logic [3:0] AC_DAC = 4'h8;
  localparam logic [3:0] AC_TCS = 4'h9;
  localparam logic [3:0] AC_STC = 4'hA;
  localparam logic [3:0] AC_DAA = 4'hB;
  localparam logic [3:0] AC_KBP = 4'hC;
  localparam logic [3:0] AC_DCL = 4'hD;

  typedef struct packed {
    logic [11:0] pc;
    logic [3:0]  acc;
    logic        carry;
    logic [2:0]  bank;
    logic [1:0]  chip;
    logic [1:0]  rsel;
    logic [3:0]  chr;
  } ncc_arch_t;

  typedef struct packed {
    logic [1:0]  stat;
    logic        exec;
    logic        two;
    logic        pair_we;
    logic [2:0]  pair_idx;
    logic [7:0]  pair_val;
    logic        ram_we;
    logic        st_we;
    logic [15:0] st_row;
    logic        push;
    logic        pop;
    logic [11:0] ret_pc;
    logic        fin;
    logic [11:0] fin_addr;
    logic        pw;
    logic [2:0]  pb;
    logic [1:0]  pcs;
    logic [3:0]  pv;
  } ncc_eff_t;

endpackage

/* rtl/core/ncc_ram.sv */
// generic synchronous ram, one write port and two registered read ports
module ncc_ram #(
  parameter int W = 8,
  parameter int D = 4096
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr_a,
  output logic [W-1:0]         rdata_a,
  input  logic [$clog2(D)-1:0] raddr_b,
  output logic [W-1:0]         rdata_b
);
  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_a_r;
  logic [W-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;
endmodule

/* rtl/core/ncc_exec.sv */
// instruction decode and execute logic for one fetched instruction
module ncc_exec import ncc_pkg::*; (
  input  ncc_arch_t   arch_i,
  input  logic [7:0]  op,
  input  logic [7:0]  dat,
  input  logic [7:0]  pair_rd,
  input  logic [3:0]  ram_nib,
  input  logic [15:0] stat_row,
  input  logic        bank_ok,
  input  logic        test_pin,
  input  logic [3:0]  rom_in,
  input  logic [11:0] stack_top,
  input  logic        here_bad,
  input  logic        next_bad,
  output ncc_arch_t   arch_o,
  output ncc_eff_t    eff
);
  logic [3:0]  hi;
  logic [3:0]  lo;
  logic        two;
  logic [11:0] here;
  logic [11:0] pcn;
  logic [3:0]  rv;
  logic [3:0]  rv_inc;
  logic [3:0]  ram_rd;
  logic [3:0]  st_rd;
  logic [3:0]  add_op;
  logic        add_en;
  logic [4:0]  sum;
  logic [4:0]  daa_sum;
  logic        cond;

  assign hi     = op[7:4];
  assign lo     = op[3:0];
  assign two    = (hi == GRP_JCN) || (hi == GRP_FIM && !lo[0]) || (hi == GRP_JUN) ||
                  (hi == GRP_JMS) || (hi == GRP_ISZ);
  assign here   = arch_i.pc;
  assign pcn    = here + (two ? 12'd2 : 12'd1);
  assign rv     = lo[0] ? pair_rd[3:0] : pair_rd[7:4];
  assign rv_inc = rv + 4'd1;
  assign ram_rd = bank_ok ? ram_nib : 4'd0;
  assign st_rd  = bank_ok ? stat_row[{lo[1:0], 2'b00} +: 4] : 4'd0;
  assign sum    = {1'b0, arch_i.acc} + {1'b0, add_op} + {4'd0, arch_i.carry};
  assign daa_sum = {1'b0, arch_i.acc} + 5'd6;

  always_comb begin
    add_op = 4'd0;
    add_en = 1'b0;
    case (hi)
      GRP_ADD: begin
        add_op = rv;
        add_en = 1'b1;
      end
      GRP_SUB: begin
        add_op = ~rv;
        add_en = 1'b1;
      end
      GRP_IO: begin
        if (lo == IO_SBM) begin
          add_op = ~ram_rd;
          add_en = 1'b1;
        end else if (lo == IO_ADM) begin
          add_op = ram_rd;
          add_en = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    cond = 1'b0;
    if (lo[2] && arch_i.acc == 4'd0) cond = 1'b1;
    if (lo[1] && arch_i.carry) cond = 1'b1;
    if (lo[0] && !test_pin) cond = 1'b1;
    if (lo[3]) cond = !cond;
  end

  always_comb begin
    arch_o = arch_i;
    eff    = '0;
    eff.two      = two;
    eff.pair_idx = lo[3:1];
    eff.ret_pc   = pcn;
    eff.st_row   = stat_row;
    eff.st_row[{lo[1:0], 2'b00} +: 4] = arch_i.acc;
    eff.fin_addr = {here[11:8], pair_rd};
    if (here_bad || (two && next_bad)) begin
      eff.stat = ST_ERR;
    end else begin
      eff.exec  = 1'b1;
      arch_o.pc = pcn;
      if (add_en) begin
        arch_o.acc   = sum[3:0];
        arch_o.carry = sum[4];
      end
      case (hi)
        GRP_JCN: begin
          if (cond) arch_o.pc = {here[11:8], dat};
        end
        GRP_FIM: begin
          if (!lo[0]) begin
            eff.pair_we  = 1'b1;
            eff.pair_val = dat;
          end else begin
            arch_o.chip = pair_rd[7:6];
            arch_o.rsel = pair_rd[5:4];
            arch_o.chr  = pair_rd[3:0];
          end
        end
        GRP_FIN: begin
          if (!lo[0]) begin
            eff.fin = 1'b1;
          end else begin
            arch_o.pc = {here[11:8], pair_rd};
          end
        end
        GRP_JUN: arch_o.pc = {lo, dat};
        GRP_JMS: begin
          eff.push  = 1'b1;
          arch_o.pc = {lo, dat};
        end
        GRP_INC, GRP_ISZ: begin
          eff.pair_we  = 1'b1;
          eff.pair_val = lo[0] ? {pair_rd[7:4], rv_inc} : {rv_inc, pair_rd[3:0]};
          if (hi == GRP_ISZ && rv_inc != 4'd0) arch_o.pc = {here[11:8], dat};
        end
        GRP_LD: arch_o.acc = rv;
        GRP_XCH: begin
          arch_o.acc   = rv;
          eff.pair_we  = 1'b1;
          eff.pair_val = lo[0] ? {pair_rd[7:4], arch_i.acc} : {arch_i.acc, pair_rd[3:0]};
        end
        GRP_BBL: begin
          arch_o.acc = lo;
          arch_o.pc  = stack_top;
          eff.pop    = 1'b1;
        end
        GRP_LDM: arch_o.acc = lo;
        GRP_IO: begin
          case (lo)
            IO_WRM: eff.ram_we = bank_ok;
            IO_WMP: begin
              eff.pw  = 1'b1;
              eff.pb  = arch_i.bank;
              eff.pcs = arch_i.chip;
              eff.pv  = arch_i.acc;
            end
            IO_WR0, IO_WR1, IO_WR2, IO_WR3: eff.st_we = bank_ok;
            IO_RDM: arch_o.acc = ram_rd;
            IO_RDR: arch_o.acc = rom_in;
            IO_RD0, IO_RD1, IO_RD2, IO_RD3: arch_o.acc = st_rd;
            default: ;
          endcase
        end
        GRP_ACC: begin
          case (lo)
            AC_CLB: begin
              arch_o.acc   = 4'd0;
              arch_o.carry = 1'b0;
            end
            AC_CLC: arch_o.carry = 1'b0;
            AC_IAC: {arch_o.carry, arch_o.acc} = {1'b0, arch_i.acc} + 5'd1;
            AC_CMC: arch_o.carry = !arch_i.carry;
            AC_CMA: arch_o.acc = ~arch_i.acc;
            AC_RAL: {arch_o.carry, arch_o.acc} = {arch_i.acc, arch_i.carry};
            AC_RAR: {arch_o.acc, arch_o.carry} = {arch_i.carry, arch_i.acc};
            AC_TCC: begin
              arch_o.acc   = {3'd0, arch_i.carry};
              arch_o.carry = 1'b0;
            end
            AC_DAC: {arch_o.carry, arch_o.acc} = {1'b0, arch_i.acc} + 5'd15;
            AC_TCS: begin
              arch_o.acc   = arch_i.carry ? 4'd10 : 4'd9;
              arch_o.carry = 1'b0;
            end
            AC_STC: arch_o.carry = 1'b1;
            AC_DAA: begin
              if (arch_i.acc > 4'd9 || arch_i.carry) begin
                arch_o.acc = daa_sum[3:0];
                if (daa_sum[4]) arch_o.carry = 1'b1;
              end
            end
            AC_KBP: begin
              case (arch_i.acc)
                4'd0, 4'd1, 4'd2: ;
                4'd4: arch_o.acc = 4'd3;
                4'd8: arch_o.acc = 4'd4;
                default: arch_o.acc = 4'd15;
              endcase
            end
            AC_DCL: arch_o.bank = arch_i.acc[2:0];
            default: ;
          endcase
        end
        default: ;
      endcase
      eff.stat = (arch_o.pc == here) ? ST_HALT : ST_OK;
    end
  end
endmodule

/* rtl/core/nibble_cpu_core_unit.sv */
// top level of the nibble processor core: sequencer, state registers and memories
//
//  channel | dir | handshake               | contents
//  in_     | in  | in_tvalid / in_tready   | tuser: req_type, tdata: load and pin fields
//  out_    | out | out_tvalid / out_tready | tdata: status, pc, acc, carry, ticks, port
//
// an item is read and executed in turn: S_IDLE registers the program store and ram read,
// S_EXE executes and writes back; a table fetch adds S_FIN for one more program store read
// after reset a clearing pass over addresses 0 to max(STORE_BYTES, RAM_BANKS*256)-1 zeroes the
// program store, data ram and status ram
// a new item is taken in S_IDLE only when the output register is free or is being
// emptied in that cycle
module nibble_cpu_core_unit import ncc_pkg::*; #(
  parameter int STORE_BYTES  = 4096,
  parameter int RAM_BANKS    = 8,
  parameter int STACK_LEVELS = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [0:0]  in_tuser,   // req_type
  input  logic [31:0] in_tdata,   // load_addr, load_byte, test_pin, rom_port_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // status, pc_out, acc_out, carry_out, tick_count,
                                  // port_write, port_bank, port_chip, port_value
);
  localparam int PAW    = $clog2(STORE_BYTES);
  localparam int DDEPTH = RAM_BANKS * 256;
  localparam int SDEPTH = RAM_BANKS * 16;
  localparam int DAW    = $clog2(DDEPTH);
  localparam int SAW    = $clog2(SDEPTH);
  localparam int CLR_N  = (STORE_BYTES > DDEPTH) ? STORE_BYTES : DDEPTH;
  localparam int CAW    = $clog2(CLR_N);
  localparam int CW     = CAW + 1;

  typedef enum logic [1:0] {S_CLR, S_IDLE, S_EXE, S_FIN} state_t;

  state_t      st_r;
  ncc_arch_t   arch_r;
  ncc_arch_t   arch_nxt;
  ncc_eff_t    eff;
  logic [7:0]  pairs_r [8];
  logic [11:0] stk_r [STACK_LEVELS];
  logic [31:0] tick_r;
  logic [31:0] tick_nxt;
  logic [CAW-1:0] clr_cnt_r;
  logic        is_load_r;
  logic        test_r;
  logic [3:0]  rom_r;
  logic        fin_ok_r;
  logic [2:0]  fin_idx_r;
  logic        out_valid_r;
  logic [63:0] out_data_r;

  logic        accept;
  logic        ld_ok;
  logic [12:0] pc_ext;
  logic        here_bad;
  logic        next_bad;
  logic [2:0]  pair_sel;
  logic [7:0]  pair_rd;
  logic        bank_ok;
  logic [DAW-1:0] daddr;
  logic [SAW-1:0] saddr;

  logic           p_we;
  logic [PAW-1:0] p_waddr;
  logic [7:0]     p_wdata;
  logic [PAW-1:0] p_raddr_b;
  logic [7:0]     p_rd_a;
  logic [7:0]     p_rd_b;
  logic           d_we;
  logic [DAW-1:0] d_waddr;
  logic [3:0]     d_wdata;
  logic [3:0]     d_rd;
  logic           s_we;
  logic [SAW-1:0] s_waddr;
  logic [15:0]    s_wdata;
  logic [15:0]    s_rd;

  assign in_tready = (st_r == S_IDLE) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;
  assign ld_ok     = {1'b0, in_tdata[11:0]} < 13'(STORE_BYTES);
  assign pc_ext    = {1'b0, arch_r.pc};
  assign here_bad  = pc_ext >= 13'(STORE_BYTES);
  assign next_bad  = (pc_ext + 13'd1) >= 13'(STORE_BYTES);
  assign bank_ok   = {1'b0, arch_r.bank} < 4'(RAM_BANKS);
  assign daddr     = DAW'({arch_r.bank, arch_r.chip, arch_r.rsel, arch_r.chr});
  assign saddr     = SAW'({arch_r.bank, arch_r.chip, arch_r.rsel});

  assign pair_sel  = (p_rd_a[7:4] == GRP_FIN && !p_rd_a[0]) ? 3'd0 : p_rd_a[3:1];
  assign pair_rd   = pairs_r[pair_sel];

  assign p_we      = (st_r == S_CLR) ? ({1'b0, clr_cnt_r} < CW'(STORE_BYTES)) :
                                       (accept && !in_tuser[0] && ld_ok);
  assign p_waddr   = (st_r == S_CLR) ? clr_cnt_r[PAW-1:0] : in_tdata[PAW-1:0];
  assign p_wdata   = (st_r == S_CLR) ? 8'd0 : in_tdata[19:12];
  assign p_raddr_b = (st_r == S_EXE) ? eff.fin_addr[PAW-1:0] : PAW'(arch_r.pc + 12'd1);

  ncc_ram #(.W(8), .D(STORE_BYTES)) u_prog (
    .clk     (clk),
    .we      (p_we),
    .waddr   (p_waddr),
    .wdata   (p_wdata),
    .raddr_a (arch_r.pc[PAW-1:0]),
    .rdata_a (p_rd_a),
    .raddr_b (p_raddr_b),
    .rdata_b (p_rd_b)
  );

  ncc_exec u_exec (
    .arch_i    (arch_r),
    .op        (p_rd_a),
    .dat       (p_rd_b),
    .pair_rd   (pair_rd),
    .ram_nib   (d_rd),
    .stat_row  (s_rd),
    .bank_ok   (bank_ok),
    .test_pin  (test_r),
    .rom_in    (rom_r),
    .stack_top (stk_r[0]),
    .here_bad  (here_bad),
    .next_bad  (next_bad),
    .arch_o    (arch_nxt),
    .eff       (eff)
  );

  logic exe_live;
  assign exe_live = (st_r == S_EXE) && !is_load_r && eff.exec;

  always_comb begin
    if (st_r == S_CLR) begin
      d_we    = {1'b0, clr_cnt_r} < CW'(DDEPTH);
      d_waddr = clr_cnt_r[DAW-1:0];
      d_wdata = 4'd0;
      s_we    = {1'b0, clr_cnt_r} < CW'(SDEPTH);
      s_waddr = clr_cnt_r[SAW-1:0];
      s_wdata = 16'd0;
    end else begin
      d_we    = exe_live && eff.ram_we;
      d_waddr = daddr;
      d_wdata = arch_r.acc;
      s_we    = exe_live && eff.st_we;
      s_waddr = saddr;
      s_wdata = eff.st_row;
    end
  end

  ncc_ram #(.W(4), .D(DDEPTH)) u_data (
    .clk     (clk),
    .we      (d_we),
    .waddr   (d_waddr),
    .wdata   (d_wdata),
    .raddr_a (daddr),
    .rdata_a (d_rd),
    .raddr_b (daddr),
    .rdata_b ()
  );

  ncc_ram #(.W(16), .D(SDEPTH)) u_stat (
    .clk     (clk),
    .we      (s_we),
    .waddr   (s_waddr),
    .wdata   (s_wdata),
    .raddr_a (saddr),
    .rdata_a (s_rd),
    .raddr_b (saddr),
    .rdata_b ()
  );

  assign tick_nxt = tick_r + (eff.two ? 32'd2 : 32'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLR;
      arch_r      <= '0;
      tick_r      <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 8; i++) pairs_r[i] <= '0;
      for (int i = 0; i < STACK_LEVELS; i++) stk_r[i] <= '0;
    end else begin
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      case (st_r)
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == CAW'(CLR_N - 1)) st_r <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            is_load_r <= !in_tuser[0];
            test_r    <= in_tdata[20];
            rom_r     <= in_tdata[24:21];
            st_r      <= S_EXE;
          end
        end
        S_EXE: begin
          if (is_load_r) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {3'd0, 9'd0, 1'b0, tick_r, arch_r.carry, arch_r.acc,
                            arch_r.pc, ST_OK};
            st_r        <= S_IDLE;
          end else if (!eff.exec) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {3'd0, 9'd0, 1'b0, tick_r, arch_r.carry, arch_r.acc,
                            arch_r.pc, eff.stat};
            st_r        <= S_IDLE;
          end else begin
            arch_r <= arch_nxt;
            tick_r <= tick_nxt;
            if (eff.pair_we) pairs_r[eff.pair_idx] <= eff.pair_val;
            if (eff.push) begin
              for (int i = STACK_LEVELS - 1; i > 0; i--) stk_r[i] <= stk_r[i-1];
              stk_r[0] <= eff.ret_pc;
            end else if (eff.pop) begin
              for (int i = 0; i < STACK_LEVELS - 1; i++) stk_r[i] <= stk_r[i+1];
              stk_r[STACK_LEVELS-1] <= '0;
            end
            if (eff.fin) begin
              fin_ok_r  <= {1'b0, eff.fin_addr} < 13'(STORE_BYTES);
              fin_idx_r <= eff.pair_idx;
              st_r      <= S_FIN;
            end else begin
              out_valid_r <= 1'b1;
              out_data_r  <= {3'd0, eff.pv, eff.pcs, eff.pb, eff.pw, tick_nxt,
                              arch_nxt.carry, arch_nxt.acc, arch_nxt.pc, eff.stat};
              st_r        <= S_IDLE;
            end
          end
        end
        S_FIN: begin
          if (fin_ok_r) pairs_r[fin_idx_r] <= p_rd_b;
          out_valid_r <= 1'b1;
          out_data_r  <= {3'd0, 9'd0, 1'b0, tick_r, arch_r.carry, arch_r.acc,
                          arch_r.pc, ST_OK};
          st_r        <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
endmodule

/* rtl/core/ncc_checker.sv */
// port-level assertions for the nibble processor core, bound to the top level
module ncc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_one_per_two: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item taken in back-to-back cycles");

  a_port_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[51] |-> out_tdata[60:52] == 9'd0)
    else $error("port fields set without a port write");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'd3)
    else $error("unknown status code");
endmodule

bind nibble_cpu_core_unit ncc_checker u_ncc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
